>>> rtl/smv_pkg.sv
package smv_pkg;

	// beat field widths
	localparam int IDX_W   = 10;
	localparam int VAL_W   = 32;
	localparam int ROW_W   = 16;
	localparam int ACC_W   = 48;
	localparam int PROD_W  = 2 * VAL_W;

	// alpha * row_sum is split at this bit of the accumulator
	localparam int SPLIT   = 24;
	localparam int PP_LO_W = VAL_W + SPLIT + 1;
	localparam int PP_HI_W = VAL_W + ACC_W - SPLIT;
	localparam int FULL_W  = VAL_W + ACC_W;
	localparam int FRAC_W  = 16;
	localparam int SCL_W   = FULL_W - FRAC_W;
	localparam int SUM_W   = SCL_W + 2;

	localparam logic signed [VAL_W-1:0] ALPHA_RESET = 32'sd65536;
	localparam logic signed [VAL_W-1:0] RES_MAX     = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] RES_MIN     = 32'sh8000_0000;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_NZ      = 2'd1,
		OP_ROW_END = 2'd2,
		OP_START   = 2'd3
	} op_t;

	// row-end beat handed from the accumulator to the scaling pipeline
	typedef struct packed {
		logic [ROW_W-1:0]          row_index;
		logic signed [VAL_W-1:0]   v1;
		logic signed [PP_LO_W-1:0] pp_lo;
		logic signed [PP_HI_W-1:0] pp_hi;
	} row_beat_t;

endpackage

>>> rtl/sparse_matrix_vector_mac_core.sv
// Sparse matrix-vector multiply-add, out[i] = v1[i] + alpha * sum_j A[i][j] * v2[j], Q16.16.
// Load beats fill the dense vector store, nonzero beats (column, value) accumulate into a
// 48-bit row sum, a row-end beat carries v1[i] and yields one result, a start beat rewinds
// the row number and clears the sum. The block takes one beat every cycle of any kind unless
// result_stall fills the row pipeline and raises item_stall; the figure is set by the 48-bit
// accumulate loop, fed by a registered read of the vector store issued on the accepting edge.
// A row-end beat passes the input, product, partial product and scaled sum stages, then the
// result register. The vector store has no reset and needs no clearing pass: a column that
// was never loaded reads as garbage. alpha (reset 1.0) may only be written while idle.
module sparse_matrix_vector_mac_core #(
	parameter int VECTOR_DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             alpha_wr_en,
	input  logic [smv_pkg::VAL_W-1:0]        alpha_wr_data,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [1:0]                       opcode,
	input  logic [smv_pkg::IDX_W-1:0]        index,
	input  logic signed [smv_pkg::VAL_W-1:0] value,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [smv_pkg::ROW_W-1:0]        row_index,
	output logic signed [smv_pkg::VAL_W-1:0] row_result,
	output logic                             saturated
);
	import smv_pkg::*;

	localparam int AW = $clog2(VECTOR_DEPTH);

	logic signed [VAL_W-1:0] alpha_q;
	logic                    accept;
	logic                    mac_ready;
	logic                    idx_ok;
	logic [AW-1:0]           addr;
	logic                    ram_we;
	logic [VAL_W-1:0]        ram_rdata;
	logic                    row_valid;
	logic                    row_ready;
	row_beat_t               row_beat;

	// alpha register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (alpha_wr_en) begin
			alpha_q <= $signed(alpha_wr_data);
		end
	end

	assign item_stall = !mac_ready;
	assign accept     = item_valid && !item_stall;

	// store address and range check
	assign addr   = AW'(index);
	assign idx_ok = 32'(index) < 32'(VECTOR_DEPTH);
	assign ram_we = accept && (op_t'(opcode) == OP_LOAD) && idx_ok;

	smv_ram #(
		.WIDTH (VAL_W),
		.DEPTH (VECTOR_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (value),
		.re    (accept),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	smv_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.opcode    (op_t'(opcode)),
		.value     (value),
		.idx_ok    (idx_ok),
		.rdata     (ram_rdata),
		.alpha     (alpha_q),
		.row_ready (row_ready),
		.ready     (mac_ready),
		.row_valid (row_valid),
		.row_beat  (row_beat)
	);

	smv_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.row_valid    (row_valid),
		.row_beat     (row_beat),
		.row_ready    (row_ready),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.row_index    (row_index),
		.row_result   (row_result),
		.saturated    (saturated)
	);

	// input backs up only when the whole row pipeline is blocked by the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("input stalled while the result side is free");

	// a clipped result sits exactly on a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && saturated) |-> (row_result == RES_MAX || row_result == RES_MIN))
		else $error("saturated result not at a rail");

	// a row-end beat waiting in the accumulator stage keeps its row number
	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(row_valid && !row_ready) |=> (row_valid && $stable(row_beat.row_index)))
		else $error("row beat changed while blocked");

endmodule

>>> rtl/smv_ram.sv
module smv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/smv_mac.sv
module smv_mac (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  smv_pkg::op_t                   opcode,
	input  logic signed [smv_pkg::VAL_W-1:0] value,
	input  logic                           idx_ok,
	input  logic [smv_pkg::VAL_W-1:0]      rdata,
	input  logic signed [smv_pkg::VAL_W-1:0] alpha,
	input  logic                           row_ready,
	output logic                           ready,
	output logic                           row_valid,
	output smv_pkg::row_beat_t             row_beat
);
	import smv_pkg::*;

	logic                    valid_s1;
	op_t                     op_s1;
	logic signed [VAL_W-1:0] value_s1;
	logic                    ok_s1;

	logic                     valid_s2;
	op_t                      op_s2;
	logic signed [VAL_W-1:0]  value_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic [ACC_W-1:0] row_sum_q;
	logic [ROW_W-1:0] row_cnt_q;

	logic signed [VAL_W-1:0]  x_vec;
	logic signed [PROD_W-1:0] prod;
	logic                     s2_free;
	logic                     s2_fire;
	logic signed [SPLIT:0]    sum_lo;
	logic signed [ACC_W-SPLIT-1:0] sum_hi;

	// stage handshake: row ends wait for the scaling pipeline, others retire
	assign s2_free = !valid_s2 || (op_s2 != OP_ROW_END) || row_ready;
	assign s2_fire = valid_s2 && s2_free;
	assign ready   = !valid_s1 || s2_free;

	// nonzero product; an out-of-range column contributes zero
	assign x_vec = ok_s1 ? $signed(rdata) : '0;
	assign prod  = PROD_W'(value_s1) * PROD_W'(x_vec);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= opcode;
			value_s1 <= value;
			ok_s1    <= idx_ok;
		end
	end

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s2_free) begin
			op_s2    <= op_s1;
			value_s2 <= value_s1;
			prod_s2  <= prod;
		end
	end

	// accumulator and row counter, updated as each beat retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q <= '0;
			row_cnt_q <= '0;
		end else if (s2_fire) begin
			unique case (op_s2)
				OP_LOAD: begin
				end
				OP_NZ: begin
					row_sum_q <= row_sum_q + prod_s2[PROD_W-1:FRAC_W];
				end
				OP_ROW_END: begin
					row_sum_q <= '0;
					row_cnt_q <= row_cnt_q + 1'b1;
				end
				OP_START: begin
					row_sum_q <= '0;
					row_cnt_q <= '0;
				end
			endcase
		end
	end

	// alpha * row_sum as two partial products, combined downstream
	assign sum_lo = $signed({1'b0, row_sum_q[SPLIT-1:0]});
	assign sum_hi = $signed(row_sum_q[ACC_W-1:SPLIT]);

	assign row_valid          = valid_s2 && (op_s2 == OP_ROW_END);
	assign row_beat.row_index = row_cnt_q;
	assign row_beat.v1        = value_s2;
	assign row_beat.pp_lo     = PP_LO_W'(alpha) * PP_LO_W'(sum_lo);
	assign row_beat.pp_hi     = PP_HI_W'(alpha) * PP_HI_W'(sum_hi);

endmodule

>>> rtl/smv_scale.sv
module smv_scale (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             row_valid,
	input  smv_pkg::row_beat_t               row_beat,
	output logic                             row_ready,
	input  logic                             result_stall,
	output logic                             result_valid,
	output logic [smv_pkg::ROW_W-1:0]        row_index,
	output logic signed [smv_pkg::VAL_W-1:0] row_result,
	output logic                             saturated
);
	import smv_pkg::*;

	logic                      valid_s3;
	logic [ROW_W-1:0]          row_s3;
	logic signed [VAL_W-1:0]   v1_s3;
	logic signed [PP_LO_W-1:0] pp_lo_s3;
	logic signed [PP_HI_W-1:0] pp_hi_s3;

	logic                    valid_s4;
	logic [ROW_W-1:0]        row_s4;
	logic signed [VAL_W-1:0] v1_s4;
	logic signed [SCL_W-1:0] scaled_s4;

	logic                    result_valid_q;
	logic [ROW_W-1:0]        row_q;
	logic signed [VAL_W-1:0] result_q;
	logic                    sat_q;

	logic                     out_free;
	logic                     s4_free;
	logic signed [FULL_W-1:0] full;
	logic signed [SUM_W-1:0]  total;
	logic                     clip;
	logic signed [VAL_W-1:0]  clamped;

	assign out_free  = !result_valid_q || !result_stall;
	assign s4_free   = !valid_s4 || out_free;
	assign row_ready = !valid_s3 || s4_free;

	// exact product, then floor by 2^16
	assign full = (FULL_W'(pp_hi_s3) <<< SPLIT) + FULL_W'(pp_lo_s3);

	// add the row base and clip to 32 bits
	assign total   = SUM_W'(scaled_s4) + SUM_W'(v1_s4);
	assign clip    = !((&total[SUM_W-1:VAL_W-1]) || !(|total[SUM_W-1:VAL_W-1]));
	assign clamped = clip ? (total[SUM_W-1] ? RES_MIN : RES_MAX) : total[VAL_W-1:0];

	// partial product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (row_ready) begin
			valid_s3 <= row_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (row_valid && row_ready) begin
			row_s3   <= row_beat.row_index;
			v1_s3    <= row_beat.v1;
			pp_lo_s3 <= row_beat.pp_lo;
			pp_hi_s3 <= row_beat.pp_hi;
		end
	end

	// scaled sum stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (s4_free) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && s4_free) begin
			row_s4    <= row_s3;
			v1_s4     <= v1_s3;
			scaled_s4 <= full[FULL_W-1:FRAC_W];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4 && out_free) begin
			row_q    <= row_s4;
			result_q <= clamped;
			sat_q    <= clip;
		end
	end

	assign result_valid = result_valid_q;
	assign row_index    = row_q;
	assign row_result   = result_q;
	assign saturated    = sat_q;

endmodule

>>> tb/smv_checker.sv
`timescale 1ns / 1ps

module smv_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             alpha_wr_en,
	input  logic [smv_pkg::VAL_W-1:0]        alpha_wr_data,
	input  logic                             item_valid,
	input  logic                             item_stall,
	input  logic [1:0]                       opcode,
	input  logic [smv_pkg::IDX_W-1:0]        index,
	input  logic signed [smv_pkg::VAL_W-1:0] value,
	input  logic                             result_valid,
	input  logic                             result_stall,
	input  logic [smv_pkg::ROW_W-1:0]        row_index,
	input  logic signed [smv_pkg::VAL_W-1:0] row_result,
	input  logic                             saturated,
	output int                               fail_count,
	output int                               rows_pending,
	output int                               rows_checked,
	output int                               rows_clipped
);
	import smv_pkg::*;

	localparam int DEPTH = 1 << IDX_W;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [VAL_W-1:0] res;
		logic             sat;
	} row_out_t;

	// mirror of the block's state, updated from the beats seen on the ports
	logic signed [VAL_W-1:0] vec_mirror [DEPTH];
	logic signed [ACC_W-1:0] acc_model;
	logic [ROW_W-1:0]        row_model;
	logic signed [VAL_W-1:0] alpha_model;
	row_out_t                rows_due [$];
	row_out_t                head;

	// Q16.16 product of a nonzero and its vector element, floored to Q32.16
	function automatic logic signed [ACC_W-1:0] nz_term(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] x);
		logic signed [PROD_W-1:0] p;
		p = a * x;
		return p[PROD_W-1:FRAC_W];
	endfunction

	// v1 + alpha * row sum, floored and clamped to 32 bits
	function automatic row_out_t row_close(input logic signed [VAL_W-1:0] v1);
		logic signed [FULL_W-1:0] prod;
		logic signed [SUM_W-1:0]  total;
		row_out_t                 o;
		prod  = alpha_model * acc_model;
		total = $signed(prod[FULL_W-1:FRAC_W]) + v1;
		o.row = row_model;
		o.sat = 1'b0;
		if (total > RES_MAX) begin
			o.res = RES_MAX;
			o.sat = 1'b1;
		end else if (total < RES_MIN) begin
			o.res = RES_MIN;
			o.sat = 1'b1;
		end else begin
			o.res = total[VAL_W-1:0];
		end
		return o;
	endfunction

	task automatic flag_field(input string name, input logic [ROW_W-1:0] row,
		input logic [VAL_W-1:0] want, input logic [VAL_W-1:0] got);
		if (got !== want) begin
			$display("%0t: row %0d %s mismatch: expected %h, got %h", $time, row, name,
				want, got);
			fail_count++;
		end
	endtask

	// the drain wait samples rows_pending on the falling edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_model    = '0;
			row_model    = '0;
			alpha_model  = ALPHA_RESET;
			rows_due.delete();
			fail_count   = 0;
			rows_pending = 0;
			rows_checked = 0;
			rows_clipped = 0;
		end else begin
			if (alpha_wr_en)
				alpha_model = alpha_wr_data;

			// result beat: compare against the oldest open row
			if (result_valid && !result_stall) begin
				if (rows_due.size() == 0) begin
					$display("%0t: unexpected row result: row %0d result %h saturated %b",
						$time, row_index, row_result, saturated);
					fail_count++;
				end else begin
					head = rows_due.pop_front();
					flag_field("row_index", head.row, VAL_W'(head.row), VAL_W'(row_index));
					flag_field("row_result", head.row, head.res, row_result);
					flag_field("saturated", head.row, VAL_W'(head.sat), VAL_W'(saturated));
					rows_checked++;
					if (head.sat)
						rows_clipped++;
				end
			end

			// input beat: advance the model
			if (item_valid && !item_stall) begin
				case (op_t'(opcode))
					OP_LOAD: vec_mirror[index] = value;
					OP_NZ: acc_model = acc_model + nz_term(value, vec_mirror[index]);
					OP_ROW_END: begin
						rows_due.push_back(row_close(value));
						acc_model = '0;
						row_model = row_model + 1'b1;
					end
					OP_START: begin
						acc_model = '0;
						row_model = '0;
					end
				endcase
			end
			rows_pending = rows_due.size();
		end
	end

endmodule

>>> tb/tb_sparse_matrix_vector_mac_core.sv
`timescale 1ns / 1ps

module tb_sparse_matrix_vector_mac_core;
	import smv_pkg::*;

	localparam int DEPTH       = 1 << IDX_W;
	localparam int SEGMENTS    = 9;
	localparam int SEG_BEATS   = 195;
	localparam int SETTLE      = 10;
	localparam int CYCLE_LIMIT = 400000;

	logic                    clk;
	logic                    arst_n;
	logic                    alpha_wr_en;
	logic [VAL_W-1:0]        alpha_wr_data;
	logic                    item_valid;
	logic                    item_stall;
	logic [1:0]              opcode;
	logic [IDX_W-1:0]        index;
	logic signed [VAL_W-1:0] value;
	logic                    result_valid;
	logic                    result_stall;
	logic [ROW_W-1:0]        row_index;
	logic signed [VAL_W-1:0] row_result;
	logic                    saturated;

	int send_idle_pct;
	int recv_stall_pct;
	int cycles;
	int beats_sent;
	int fail_count;
	int rows_pending;
	int rows_checked;
	int rows_clipped;

	// columns that hold a loaded vector element
	logic loaded [DEPTH];
	int   loaded_cols [$];

	sparse_matrix_vector_mac_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.alpha_wr_en   (alpha_wr_en),
		.alpha_wr_data (alpha_wr_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.opcode        (opcode),
		.index         (index),
		.value         (value),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.row_index     (row_index),
		.row_result    (row_result),
		.saturated     (saturated)
	);

	smv_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.alpha_wr_en   (alpha_wr_en),
		.alpha_wr_data (alpha_wr_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.opcode        (opcode),
		.index         (index),
		.value         (value),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.row_index     (row_index),
		.row_result    (row_result),
		.saturated     (saturated),
		.fail_count    (fail_count),
		.rows_pending  (rows_pending),
		.rows_checked  (rows_checked),
		.rows_clipped  (rows_clipped)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver backpressure
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d row results outstanding", $time, rows_pending);
			$display("simulation failed");
			$finish;
		end
	end

	// Q16.16 operand: mostly small magnitudes, some full range, some corner values
	function automatic logic [VAL_W-1:0] rand_q16();
		logic [VAL_W-1:0] v;
		int               pick;
		pick = $urandom_range(99);
		if (pick < 50) begin
			v = $urandom_range(4 << FRAC_W);
			if ($urandom_range(1))
				v = -v;
		end else if (pick < 85) begin
			v = $urandom;
		end else begin
			case ($urandom_range(6))
				0: v = 32'h7FFF_FFFF;
				1: v = 32'h8000_0000;
				2: v = 32'h0000_0000;
				3: v = 32'h0001_0000;
				4: v = 32'hFFFF_0000;
				5: v = 32'h0000_0001;
				default: v = 32'hFFFF_FFFF;
			endcase
		end
		return v;
	endfunction

	function automatic logic [IDX_W-1:0] rand_col();
		return IDX_W'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
	endfunction

	function automatic logic [VAL_W-1:0] alpha_for(input int seg);
		case (seg)
			0: return 32'h7FFF_FFFF;
			1: return 32'h0000_0000;
			2: return 32'h0001_8000;
			3: return 32'h8000_0000;
			4: return 32'hFFFF_0000;
			5: return $urandom;
			6: return 32'h0000_0001;
			7: return 32'hFFFF_FFFF;
			default: return $urandom_range(1 << 18);
		endcase
	endfunction

	// present one beat and hold it until accepted; stall is read mid-cycle
	task automatic send_beat(input op_t op, input logic [IDX_W-1:0] col,
		input logic [VAL_W-1:0] val);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		opcode     <= op;
		index      <= col;
		value      <= val;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !item_stall;
			@(posedge clk);
		end
		beats_sent++;
	endtask

	task automatic send_load(input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val);
		if (!loaded[col]) begin
			loaded[col] = 1'b1;
			loaded_cols.push_back(int'(col));
		end
		send_beat(OP_LOAD, col, val);
	endtask

	// block idle: no row outstanding, then room for beats that yield nothing
	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(negedge clk); while (rows_pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_alpha(input logic [VAL_W-1:0] a);
		wait_drained();
		alpha_wr_en   <= 1'b1;
		alpha_wr_data <= a;
		@(posedge clk);
		alpha_wr_en   <= 1'b0;
	endtask

	// mostly complete rows, with reloads, empty and long rows, and restarts mid-row
	task automatic gen_traffic(input int n);
		int stop;
		int k;
		stop = beats_sent + n;
		while (beats_sent < stop) begin
			case ($urandom_range(19))
				0: send_beat(OP_START, IDX_W'($urandom), rand_q16());
				1, 2: send_load(IDX_W'($urandom_range(DEPTH - 1)), rand_q16());
				default: begin
					k = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
					repeat (k) begin
						if ($urandom_range(49) == 0)
							send_beat(OP_START, IDX_W'($urandom), rand_q16());
						send_beat(OP_NZ, rand_col(), rand_q16());
					end
					send_beat(OP_ROW_END, IDX_W'($urandom), rand_q16());
				end
			endcase
		end
	endtask

	initial begin
		int seg;
		arst_n         = 1'b0;
		alpha_wr_en    = 1'b0;
		alpha_wr_data  = '0;
		item_valid     = 1'b0;
		opcode         = OP_LOAD;
		index          = '0;
		value          = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		beats_sent     = 0;
		foreach (loaded[i])
			loaded[i] = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme elements at both ends of the store
		send_load(IDX_W'(0), 32'h7FFF_FFFF);
		send_load(IDX_W'(DEPTH - 1), 32'h8000_0000);
		send_load(IDX_W'(1), 32'h0001_0000);
		send_load(IDX_W'(2), 32'hFFFF_0000);
		send_load(IDX_W'(3), 32'h0000_0001);
		// row with no nonzeros
		send_beat(OP_ROW_END, IDX_W'(0), 32'h0005_0000);
		// clip high
		send_beat(OP_NZ, IDX_W'(0), 32'h7FFF_FFFF);
		send_beat(OP_NZ, IDX_W'(0), 32'h7FFF_FFFF);
		send_beat(OP_ROW_END, IDX_W'(0), 32'h7FFF_FFFF);
		// clip low
		send_beat(OP_NZ, IDX_W'(DEPTH - 1), 32'h7FFF_FFFF);
		send_beat(OP_NZ, IDX_W'(DEPTH - 1), 32'h7FFF_FFFF);
		send_beat(OP_ROW_END, IDX_W'(0), 32'h8000_0000);
		// negative products floor toward minus infinity
		send_beat(OP_NZ, IDX_W'(3), 32'hFFFF_FFFF);
		send_beat(OP_NZ, IDX_W'(2), 32'h0000_0003);
		send_beat(OP_ROW_END, IDX_W'(0), 32'h0000_0000);
		// four 2^46 terms wrap the 48-bit sum back to zero
		repeat (4)
			send_beat(OP_NZ, IDX_W'(DEPTH - 1), 32'h8000_0000);
		send_beat(OP_ROW_END, IDX_W'(0), 32'h0000_0000);
		// start rewinds the row number and drops the partial sum
		send_beat(OP_NZ, IDX_W'(1), 32'h0003_0000);
		send_beat(OP_START, IDX_W'(0), 32'h0000_0000);
		send_beat(OP_NZ, IDX_W'(1), 32'h0002_0000);
		send_beat(OP_ROW_END, IDX_W'(0), 32'hFFFF_0000);

		// random: alpha sweep over three idle/stall mixes
		for (seg = 0; seg < SEGMENTS; seg++) begin
			write_alpha(alpha_for(seg));
			case (seg / 3)
				0: begin
					send_idle_pct  = 17;
					recv_stall_pct = 84;
				end
				1: begin
					send_idle_pct  = 84;
					recv_stall_pct = 17;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			gen_traffic(SEG_BEATS);
		end
		wait_drained();

		$display("%0d beats accepted, %0d row results checked, %0d of them clipped",
			beats_sent, rows_checked, rows_clipped);
		$display("alpha swept through %0d settings incl. both extremes, three handshake mixes",
			SEGMENTS);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
